// ===== hdl/mabr_pkg.sv =====
package mabr_pkg;
  localparam int MAX_RADIUS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int RING_DEPTH  = 2 * MAX_RADIUS;
  localparam int PTR_BITS    = $clog2(RING_DEPTH);
  localparam int CNT_BITS    = $clog2(RING_DEPTH + 1);
  localparam int RAD_BITS    = $clog2(MAX_RADIUS + 1);
  localparam int SUM_BITS    = SAMPLE_BITS + CNT_BITS - 1;
  localparam int OUT_BITS    = SAMPLE_BITS + 1;
  localparam int REG_BITS    = 6;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB_RD,
    ST_SUB,
    ST_WRITE,
    ST_CTR_RD,
    ST_DIV,
    ST_OUT,
    ST_FL_TRIM_RD,
    ST_FL_TRIM,
    ST_FL_CTR_RD,
    ST_FL_NEXT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic rd_old;
    logic sub_old;
    logic write_new;
    logic rd_center;
    logic div_start;
    logic out_valid;
    logic fl_init;
    logic rd_trim;
    logic trim;
    logic rd_fl_center;
    logic fl_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic need_sub;
    logic do_emit;
    logic fl_empty;
    logic fl_need_trim;
    logic fl_last;
    logic div_done;
    logic out_taken;
  } status_t;
endpackage

// ===== hdl/moving_average_baseline_remover_unit.sv =====
// Centered moving-average baseline remover, one channel. Each sample beat
// (tuser=0) stores the sample and, once R more frames have arrived, yields the
// sample minus the truncated mean of frames n-R+1..n+R. An end-of-record beat
// (tuser=1) flushes the remaining min(R, frames) results with shrinking windows,
// marks the last with tlast and starts a new record. One item is handled at a
// time: a sample that yields a result goes through a ring read, a sum update,
// a bit-serial divide by the window count and an output state before the next
// beat is accepted; a sample with no result only updates the ring and the sum.
// Each flushed result first trims the frames that left its window, and a flush
// ends with a clear state. Output stalls hold the unit in its output state.
// Writing window_radius restarts the record.
module moving_average_baseline_remover_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] sample_value
  input  logic        s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // [16:0] detrended_value, rest zero
  output logic        m_tlast,  // last_of_record
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mabr_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    busy, in_beat, cfg_we;
  logic [REG_BITS-1:0]  radius_reg;
  logic [OUT_BITS-1:0]  out_value;

  assign s_tready = !busy;
  assign in_beat  = s_tvalid && s_tready;
  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata   = (paddr == 2'd0) ? {26'd0, radius_reg} : 32'd0;
  assign m_tvalid = cmd.out_valid;
  assign m_tdata  = {7'd0, out_value};

  mabr_ctrl u_ctrl (
    .clk, .rst, .in_beat, .in_func(s_tuser), .sts, .cmd, .busy
  );

  mabr_dp u_dp (
    .clk, .rst, .in_sample(s_tdata), .cfg_we, .cfg_data(pwdata[REG_BITS-1:0]),
    .cmd, .out_ready(m_tready), .sts, .radius_reg, .out_value,
    .out_last(m_tlast)
  );
endmodule

// ===== hdl/mabr_ctrl.sv =====
module mabr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_beat,
  input  logic              in_func,
  input  mabr_pkg::status_t sts,
  output mabr_pkg::cmd_t    cmd,
  output logic              busy
);
  import mabr_pkg::*;

  state_t state, state_next;
  logic   flushing, flushing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      flushing <= 1'b0;
    end else begin
      state    <= state_next;
      flushing <= flushing_next;
    end
  end

  always_comb begin
    state_next    = state;
    flushing_next = flushing;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_func == FUNC_FLUSH) begin
            flushing_next = 1'b1;
            state_next    = sts.fl_empty ? ST_CLEAR : ST_FL_TRIM_RD;
          end else begin
            flushing_next = 1'b0;
            state_next    = sts.need_sub ? ST_SUB_RD : ST_WRITE;
          end
        end
      end
      ST_SUB_RD:     state_next = ST_SUB;
      ST_SUB:        state_next = ST_WRITE;
      ST_WRITE:      state_next = sts.do_emit ? ST_CTR_RD : ST_IDLE;
      ST_CTR_RD:     state_next = ST_DIV;
      ST_DIV:        if (sts.div_done) state_next = ST_OUT;
      ST_OUT: begin
        if (sts.out_taken) begin
          if (!flushing)       state_next = ST_IDLE;
          else if (sts.fl_last) state_next = ST_CLEAR;
          else                 state_next = ST_FL_NEXT;
        end
      end
      ST_FL_NEXT:    state_next = ST_FL_TRIM_RD;
      ST_FL_TRIM_RD: state_next = sts.fl_need_trim ? ST_FL_TRIM : ST_FL_CTR_RD;
      ST_FL_TRIM:    state_next = ST_FL_TRIM_RD;
      ST_FL_CTR_RD:  state_next = ST_CTR_RD;
      ST_CLEAR:      state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.fl_init = in_beat && (in_func == FUNC_FLUSH);
        cmd.rd_old  = in_beat && (in_func == FUNC_SAMPLE);
      end
      ST_SUB:        cmd.sub_old = 1'b1;
      ST_WRITE:      cmd.write_new = 1'b1;
      ST_CTR_RD:     cmd.rd_center = 1'b1;
      ST_DIV:        cmd.div_start = 1'b0;
      ST_OUT:        cmd.out_valid = 1'b1;
      ST_FL_NEXT:    cmd.fl_step = 1'b1;
      ST_FL_TRIM_RD: cmd.rd_trim = 1'b1;
      ST_FL_TRIM:    cmd.trim = 1'b1;
      ST_FL_CTR_RD:  cmd.rd_fl_center = 1'b1;
      ST_CLEAR:      cmd.clear = 1'b1;
      default:       cmd = '0;
    endcase
    cmd.div_start = (state == ST_CTR_RD);
  end
endmodule

// ===== hdl/mabr_dp.sv =====
module mabr_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [mabr_pkg::SAMPLE_BITS-1:0]   in_sample,
  input  logic                               cfg_we,
  input  logic [mabr_pkg::REG_BITS-1:0]      cfg_data,
  input  mabr_pkg::cmd_t                     cmd,
  input  logic                               out_ready,
  output mabr_pkg::status_t                  sts,
  output logic [mabr_pkg::REG_BITS-1:0]      radius_reg,
  output logic [mabr_pkg::OUT_BITS-1:0]      out_value,
  output logic                               out_last
);
  import mabr_pkg::*;

  localparam int QB = SUM_BITS;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [PTR_BITS-1:0]    rd_addr;
  logic                   rd_en;

  logic signed [SUM_BITS-1:0] wsum;
  logic [CNT_BITS-1:0]        frames;
  logic [PTR_BITS-1:0]        wptr;
  logic [SAMPLE_BITS-1:0]     new_sample;

  // flush bookkeeping
  logic [RAD_BITS-1:0] fl_p, fl_i;
  logic [CNT_BITS-1:0] fl_cnt;
  logic signed [SUM_BITS-1:0] fl_sum;
  logic flushing;

  logic [RAD_BITS-1:0] r;
  logic [CNT_BITS-1:0] full, need, frames_inc;

  always_comb begin
    if (radius_reg == '0) r = RAD_BITS'(1);
    else if (radius_reg > REG_BITS'(MAX_RADIUS)) r = RAD_BITS'(MAX_RADIUS);
    else r = RAD_BITS'(radius_reg);
    full = CNT_BITS'(r) << 1;
    frames_inc = (frames < full) ? frames + 1'b1 : frames;
    // target count for current flush output
    need = CNT_BITS'(fl_p - 1'b1 - fl_i) + CNT_BITS'(r);
    if (need > frames) need = frames;
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    if (cmd.rd_old)
      rd_addr = wptr - PTR_BITS'(full);
    else if (cmd.rd_center)
      rd_addr = flushing ? (wptr - PTR_BITS'(fl_p) + PTR_BITS'(fl_i))
                         : (wptr - PTR_BITS'(1) - PTR_BITS'(r));
    else if (cmd.rd_trim)
      rd_addr = wptr - PTR_BITS'(fl_cnt);
    else
      rd_en = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.write_new) ring[wptr] <= new_sample;
    if (rd_en) rd_data <= ring[rd_addr];
  end

  // divider: restoring, magnitude over magnitude, one bit per cycle
  // center sample stays in rd_data while the divide runs (no reads then)
  logic [QB-1:0]         dv_rem_q, dv_quot;
  logic [CNT_BITS:0]     dv_part;
  logic [CNT_BITS-1:0]   dv_den;
  logic [$clog2(QB+1)-1:0] dv_n;
  logic                  dv_neg, dv_busy;
  logic [CNT_BITS:0]     dv_trial;

  assign dv_trial = {dv_part[CNT_BITS-1:0], dv_rem_q[QB-1]};
  assign sts.div_done = dv_busy && (dv_n == '0);

  logic signed [SUM_BITS-1:0] div_sum;
  logic [CNT_BITS-1:0]        div_cnt;
  assign div_sum = flushing ? fl_sum : wsum;
  assign div_cnt = flushing ? fl_cnt : frames;

  logic signed [SUM_BITS:0] mean_s;
  logic signed [OUT_BITS:0] diff;
  always_comb begin
    mean_s = dv_neg ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
    diff = (OUT_BITS+1)'($signed(rd_data)) - (OUT_BITS+1)'(mean_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_reg <= REG_BITS'(1);
      wsum <= '0; frames <= '0; wptr <= '0;
      dv_busy <= 1'b0; flushing <= 1'b0;
      fl_p <= '0; fl_i <= '0; fl_cnt <= '0; fl_sum <= '0;
      out_value <= '0; out_last <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_reg <= cfg_data;
        wsum <= '0; frames <= '0; wptr <= '0;
      end
      if (cmd.rd_old) begin
        new_sample <= in_sample;
        flushing <= 1'b0;
      end
      if (cmd.sub_old) wsum <= wsum - SUM_BITS'($signed(rd_data));
      if (cmd.write_new) begin
        wsum   <= wsum + SUM_BITS'($signed(new_sample));
        wptr   <= wptr + 1'b1;
        frames <= frames_inc;
      end
      if (cmd.fl_init) begin
        flushing <= 1'b1;
        fl_p   <= (frames < CNT_BITS'(r)) ? RAD_BITS'(frames) : r;
        fl_i   <= '0;
        fl_cnt <= frames;
        fl_sum <= wsum;
      end
      if (cmd.trim) begin
        fl_sum <= fl_sum - SUM_BITS'($signed(rd_data));
        fl_cnt <= fl_cnt - 1'b1;
      end
      if (cmd.fl_step) fl_i <= fl_i + 1'b1;
      if (cmd.div_start) begin
        dv_neg   <= div_sum[SUM_BITS-1];
        dv_rem_q <= div_sum[SUM_BITS-1] ? QB'(-div_sum) : QB'(div_sum);
        dv_part  <= '0;
        dv_den   <= div_cnt;
        dv_n     <= ($clog2(QB+1))'(QB);
        dv_busy  <= 1'b1;
      end else if (dv_busy && dv_n != '0) begin
        dv_n <= dv_n - 1'b1;
        if (dv_trial >= {1'b0, dv_den}) begin
          dv_part  <= dv_trial - {1'b0, dv_den};
          dv_rem_q <= {dv_rem_q[QB-2:0], 1'b1};
        end else begin
          dv_part  <= dv_trial;
          dv_rem_q <= {dv_rem_q[QB-2:0], 1'b0};
        end
      end else if (sts.div_done) begin
        dv_busy   <= 1'b0;
        out_value <= diff[OUT_BITS-1:0];
        out_last  <= flushing && (fl_i + 1'b1 == fl_p);
      end
      if (cmd.clear) begin
        wsum <= '0; frames <= '0; wptr <= '0;
      end
    end
  end
  assign dv_quot = dv_rem_q;

  assign sts.need_sub     = (frames >= full);
  assign sts.do_emit      = (frames_inc >= CNT_BITS'(r) + 1'b1);
  assign sts.fl_empty     = (frames == '0);
  assign sts.fl_need_trim = (fl_cnt > need);
  assign sts.fl_last      = (fl_i + 1'b1 == fl_p);
  assign sts.out_taken    = cmd.out_valid && out_ready;
endmodule

// ===== tb/tb.sv =====
module tb;
  import mabr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic                   func;
    logic [SAMPLE_BITS-1:0] sample;
  } beat_t;

  typedef struct {
    logic [OUT_BITS-1:0] detrended;
    logic                last;
  } result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] sample_value
  logic        s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [16:0] detrended_value, rest zero
  logic        m_tlast;   // last_of_record
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  moving_average_baseline_remover_unit u_dut (.*);

  beat_t   pending_beats[$];
  result_t expected_results[$];
  int      errors;
  int      quiet_cycles;
  bit      src_idle_on;
  bit      sink_idle_on;
  bit      sink_hold;
  int      src_gap;
  int      sink_gap;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] hist[RING_DEPTH];
  longint                        win_sum;
  int                            n_frames;
  int                            wr_ptr;
  int                            radius_reg;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint hist_at(int pos);
    return longint'(hist[pos % RING_DEPTH]);
  endfunction

  function automatic void push_result(longint samp, longint sum, int cnt, bit last);
    longint  mean;
    result_t res;
    mean = (cnt != 0) ? sum / cnt : 0;
    res.detrended = OUT_BITS'(samp - mean);
    res.last = last;
    expected_results.push_back(res);
  endfunction

  function automatic void predict_baseline(beat_t b);
    int     r;
    int     full;
    int     p;
    int     cnt;
    int     need;
    longint sum;
    r = radius_reg < 1 ? 1 : (radius_reg > MAX_RADIUS ? MAX_RADIUS : radius_reg);
    full = 2 * r;
    if (b.func == FUNC_SAMPLE) begin
      if (n_frames >= full) win_sum -= hist_at(wr_ptr + RING_DEPTH - full);
      hist[wr_ptr] = b.sample;
      win_sum += longint'($signed(b.sample));
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      if (n_frames < full) n_frames++;
      if (n_frames >= r + 1)
        push_result(hist_at(wr_ptr + RING_DEPTH - 1 - r), win_sum, n_frames, 0);
    end else begin
      p = n_frames < r ? n_frames : r;
      cnt = n_frames;
      sum = win_sum;
      for (int i = 0; i < p; i++) begin
        need = p - 1 - i + r;
        if (need > n_frames) need = n_frames;
        while (cnt > need) begin
          sum -= hist_at(wr_ptr + RING_DEPTH - cnt);
          cnt--;
        end
        push_result(hist_at(wr_ptr + RING_DEPTH - p + i), sum, cnt, i + 1 == p);
      end
      win_sum = 0;
      n_frames = 0;
      wr_ptr = 0;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      src_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_baseline(pending_beats.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_tvalid <= 0;
      end else if ((!s_tvalid || s_tready) && src_idle_on && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 9);
        s_tvalid <= 0;
      end else if (pending_beats.size() > 0 && (!s_tvalid || s_tready ||
                   pending_beats.size() > 0)) begin
        s_tvalid <= 1;
        s_tuser <= pending_beats[0].func;
        s_tdata <= pending_beats[0].sample;
      end else begin
        s_tvalid <= 0;
      end
    end
  end

  // sink stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      sink_gap <= 0;
    end else if (sink_hold) begin
      m_tready <= 0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 9);
      m_tready <= 0;
    end else begin
      m_tready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected beat: detrended_value %h last %b", m_tdata[16:0], m_tlast);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        if (m_tdata[16:0] !== exp_res.detrended) begin
          $error("detrended_value expected %h actual %h", exp_res.detrended, m_tdata[16:0]);
          errors++;
        end
        if (m_tlast !== exp_res.last) begin
          $error("last_of_record expected %b actual %b", exp_res.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || sink_hold)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_radius(int value);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= 2'd0;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    radius_reg = value & 63;
    win_sum = 0;
    n_frames = 0;
    wr_ptr = 0;
  endtask

  task automatic wait_drained();
    while (pending_beats.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    // flush of an empty record or a sample with no result may still be busy
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_record(int len, bit flush);
    beat_t b;
    for (int i = 0; i < len; i++) begin
      b.func = FUNC_SAMPLE;
      b.sample = pick_sample();
      pending_beats.push_back(b);
    end
    if (flush) begin
      b.func = FUNC_FLUSH;
      b.sample = 16'($urandom);
      pending_beats.push_back(b);
    end
  endtask

  initial begin
    int radii[6] = '{1, 32, 0, 63, 5, 3};
    beat_t b;
    errors = 0;
    rst = 1;
    s_tdata = 0;
    s_tuser = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    src_idle_on = 1;
    sink_idle_on = 1;
    sink_hold = 0;
    radius_reg = 1;
    win_sum = 0;
    n_frames = 0;
    wr_ptr = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    wait_drained();

    // directed: empty flush, extremes, short record, flush with ignored sample, one-sample record
    b.func = FUNC_FLUSH; b.sample = 16'hffff;
    pending_beats.push_back(b);
    foreach (radii[k]) begin end
    b.func = FUNC_SAMPLE;
    b.sample = 16'h7fff; pending_beats.push_back(b);
    b.sample = 16'h8000; pending_beats.push_back(b);
    b.sample = 16'h7fff; pending_beats.push_back(b);
    b.sample = 16'h0000; pending_beats.push_back(b);
    b.sample = 16'h8000; pending_beats.push_back(b);
    b.func = FUNC_FLUSH; b.sample = 16'h5a5a; pending_beats.push_back(b);
    b.func = FUNC_SAMPLE; b.sample = 16'h8000; pending_beats.push_back(b);
    b.func = FUNC_FLUSH; pending_beats.push_back(b);
    wait_drained();

    foreach (radii[k]) begin
      write_radius(radii[k]);
      if (k == 1) begin
        // long receiver hold-off while the sender keeps offering beats
        sink_hold = 1;
        queue_record(70, 1);
        repeat (3000) @(posedge clk);
        sink_hold = 0;
      end else begin
        for (int j = 0; j < 6; j++)
          queue_record($urandom_range(0, 14), $urandom_range(0, 5) != 0);
      end
      if (k == 5) begin
        src_idle_on = 0;
        sink_idle_on = 0;
        queue_record(40, 1);
      end
      wait_drained();
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// ===== moving_average_baseline_remover_unit.f =====
hdl/mabr_pkg.sv
hdl/mabr_ctrl.sv
hdl/mabr_dp.sv
hdl/moving_average_baseline_remover_unit.sv
tb/tb.sv
